// File: rtl/tke_pkg.sv
package tke_pkg;

    localparam int ENTRIES      = 16;
    localparam int IDX_BITS     = $clog2(ENTRIES);
    localparam int CNT_BITS     = $clog2(ENTRIES + 1);
    localparam int PAYLOAD_BITS = 64;
    localparam int TIME_BITS    = 32;
    localparam int KEY_BITS     = 256;

    typedef enum logic [2:0] {
        CMD_LOOKUP = 3'd0,
        CMD_STORE  = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_EXPIRE = 3'd3,
        CMD_TICK   = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_SWEEP,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;       // capture the incoming word, clear scan state
        logic rd;         // read the slot at the scan index
        logic step;       // evaluate the slot read last cycle
        logic sweep_mode; // step acts as a sweep
        logic finish;     // resolve the command and load the result
        logic tick;
        logic idx_clr;
    } t_ctl;

    // datapath to controller
    typedef struct packed {
        logic last;       // slot just evaluated is the last one
        logic stop;       // scan can end early
        logic need_sweep; // no free slot found so far
    } t_sts;

endpackage

// File: rtl/tke_ctrl.sv
module tke_ctrl
    import tke_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_cmd i_cmd,
    input  t_sts i_sts,
    input  logic i_out_free,
    output logic o_busy,
    output t_ctl o_ctl
);

    t_state r_state, n_state;
    logic   r_swept, n_swept;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_swept <= 1'b0;
        end else begin
            r_state <= n_state;
            r_swept <= n_swept;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_swept = r_swept;
        o_ctl   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_ctl.load    = 1'b1;
                    o_ctl.idx_clr = 1'b1;
                    n_swept       = 1'b0;
                    n_state       = S_READ;
                end
            end
            S_READ: begin
                if (i_cmd == CMD_LOOKUP || i_cmd == CMD_STORE || i_cmd == CMD_REMOVE ||
                    i_cmd == CMD_EXPIRE) begin
                    o_ctl.rd = 1'b1;
                    n_state  = (i_cmd == CMD_EXPIRE) ? S_SWEEP : S_SCAN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SCAN: begin
                o_ctl.step = 1'b1;
                o_ctl.rd   = 1'b1;
                if (i_sts.stop || i_sts.last) begin
                    o_ctl.rd = 1'b0;
                    if (i_sts.last && !i_sts.stop && i_sts.need_sweep && !r_swept) begin
                        o_ctl.idx_clr = 1'b1;
                        n_swept       = 1'b1;
                        n_state       = S_READ;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_SWEEP: begin
                o_ctl.step       = 1'b1;
                o_ctl.sweep_mode = 1'b1;
                o_ctl.rd         = 1'b1;
                // a store takes the first slot the sweep frees, so no rescan
                if (i_sts.last) begin
                    o_ctl.rd = 1'b0;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_ctl.finish = 1'b1;
                    o_ctl.tick   = (i_cmd == CMD_TICK);
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        // a store with no free slot sweeps once its first pass ends
        if (r_state == S_READ && i_cmd == CMD_STORE && r_swept && n_state == S_SCAN &&
            !o_ctl.sweep_mode && i_sts.need_sweep) begin
            n_state = S_SWEEP;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |-> r_state == S_IDLE)
        else $error("load outside idle");
    a_finish_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.finish |=> r_state == S_IDLE)
        else $error("finish did not return to idle");
    a_rd_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.rd |=> (r_state == S_SCAN || r_state == S_SWEEP))
        else $error("read not followed by evaluate");

endmodule

// File: rtl/tke_datapath.sv
module tke_datapath
    import tke_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_ctl                    i_ctl,
    input  logic [2:0]              i_command,
    input  logic [KEY_BITS-1:0]     i_key,
    input  logic [PAYLOAD_BITS-1:0] i_payload,
    input  logic [15:0]             i_lifetime,
    input  logic [15:0]             i_default_lifetime,
    output t_sts                    o_sts,
    output logic [1:0]              o_status,
    output logic [PAYLOAD_BITS-1:0] o_payload,
    output logic [4:0]              o_cleared,
    output logic [4:0]              o_count
);

    logic [KEY_BITS-1:0]     r_key_mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0] r_pay_mem [ENTRIES];
    logic [TIME_BITS-1:0]    r_exp_mem [ENTRIES];
    logic [ENTRIES-1:0]      r_valid;
    logic [CNT_BITS-1:0]     r_live;
    logic [TIME_BITS-1:0]    r_time;

    logic [2:0]              r_cmd;
    logic [KEY_BITS-1:0]     r_key;
    logic [PAYLOAD_BITS-1:0] r_pay;
    logic [TIME_BITS-1:0]    r_new_exp;
    logic [IDX_BITS-1:0]     r_idx, r_eidx;
    logic [KEY_BITS-1:0]     r_rd_key;
    logic [PAYLOAD_BITS-1:0] r_rd_pay;
    logic [TIME_BITS-1:0]    r_rd_exp;
    logic                    r_hit, r_have_free;
    logic [IDX_BITS-1:0]     r_hit_idx, r_free_idx;
    logic [PAYLOAD_BITS-1:0] r_hit_pay;
    logic [CNT_BITS-1:0]     r_cleared;

    logic slot_valid, slot_expired, slot_match, drop, found;
    logic [15:0] life;

    assign slot_valid   = r_valid[r_eidx];
    assign slot_expired = r_rd_exp < r_time;
    assign slot_match   = (r_rd_key == r_key);
    assign life         = (i_lifetime != 16'd0) ? i_lifetime : i_default_lifetime;

    // hit condition per command at the slot being evaluated
    always_comb begin
        found = 1'b0;
        drop  = 1'b0;
        if (i_ctl.step) begin
            if (i_ctl.sweep_mode) begin
                drop = slot_valid && slot_expired;
            end else begin
                case (t_cmd'(r_cmd))
                    CMD_LOOKUP: begin
                        drop  = slot_valid && slot_expired;
                        found = slot_valid && !slot_expired && slot_match;
                    end
                    CMD_STORE:  found = slot_valid && slot_match;
                    CMD_REMOVE: begin
                        found = slot_valid && slot_match;
                        drop  = found;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_sts.stop       = found || (r_cmd == CMD_STORE && !i_ctl.sweep_mode &&
                                        r_have_free && r_hit);
    assign o_sts.last       = (r_eidx == IDX_BITS'(ENTRIES - 1));
    assign o_sts.need_sweep = !r_have_free && !(i_ctl.step && !slot_valid);

    // command capture, scan and result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_live  <= '0;
            r_time  <= '0;
        end else begin
            if (i_ctl.load) begin
                r_cmd       <= i_command;
                r_key       <= i_key;
                r_pay       <= i_payload;
                r_new_exp   <= r_time + TIME_BITS'(life);
                r_hit       <= 1'b0;
                r_have_free <= 1'b0;
                r_cleared   <= '0;
            end
            if (i_ctl.idx_clr) begin
                r_idx <= '0;
            end
            if (i_ctl.rd) begin
                r_rd_key <= r_key_mem[r_idx];
                r_rd_pay <= r_pay_mem[r_idx];
                r_rd_exp <= r_exp_mem[r_idx];
                r_eidx   <= r_idx;
                r_idx    <= r_idx + 1'b1;
            end
            if (drop) begin
                r_valid[r_eidx] <= 1'b0;
                r_live          <= r_live - 1'b1;
                if (i_ctl.sweep_mode) begin
                    r_cleared <= r_cleared + 1'b1;
                end
                if (!r_have_free && r_cmd == CMD_STORE) begin
                    r_have_free <= 1'b1;
                    r_free_idx  <= r_eidx;
                end
            end
            if (i_ctl.step && !i_ctl.sweep_mode && !slot_valid && !r_have_free) begin
                r_have_free <= 1'b1;
                r_free_idx  <= r_eidx;
            end
            if (found) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_eidx;
                r_hit_pay <= r_rd_pay;
            end
            if (i_ctl.finish) begin
                o_payload <= '0;
                o_cleared <= '0;
                o_status  <= ST_OK;
                case (t_cmd'(r_cmd))
                    CMD_LOOKUP: begin
                        if (r_hit) o_payload <= r_hit_pay;
                        else       o_status  <= ST_NOT_FOUND;
                    end
                    CMD_REMOVE: if (!r_hit) o_status <= ST_NOT_FOUND;
                    CMD_EXPIRE: o_cleared <= 5'(r_cleared);
                    CMD_STORE: begin
                        if (r_hit) begin
                            r_pay_mem[r_hit_idx] <= r_pay;
                            r_exp_mem[r_hit_idx] <= r_new_exp;
                        end else if (r_have_free) begin
                            r_key_mem[r_free_idx] <= r_key;
                            r_pay_mem[r_free_idx] <= r_pay;
                            r_exp_mem[r_free_idx] <= r_new_exp;
                            r_valid[r_free_idx]   <= 1'b1;
                        end else begin
                            o_status <= ST_FULL;
                        end
                    end
                    default: ;
                endcase
                if (r_cmd == CMD_STORE && !r_hit && r_have_free) begin
                    o_count <= 5'(r_live + 1'b1);
                    r_live  <= r_live + 1'b1;
                end else begin
                    o_count <= 5'(r_live);
                end
                if (i_ctl.tick) begin
                    r_time <= r_time + 1'b1;
                end
            end
        end
    end

    a_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_live == CNT_BITS'($countones(r_valid)))
        else $error("live count out of step with valid bits");
    a_drop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        drop |-> slot_valid)
        else $error("dropping an invalid slot");
    a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.tick |=> $stable(r_time))
        else $error("time moved without a tick");

endmodule

// File: rtl/ttl_keyed_endpoint_table.sv
// Keyed endpoint table with expiry: sixteen slots, each a 256-bit key, a 64-bit payload and
// an expiry second. One command word at a time; lookup, store and remove scan the slots one
// per cycle, expire sweeps all 16, a store into a full table sweeps after its scan, and
// a lookup or remove that misses in a full table scans it twice. The next word is taken once
// the result is in the output register. Valid bits clear at reset; no clearing pass.
module ttl_keyed_endpoint_table
    import tke_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_command,
    input  logic [63:0] i_key_word0,
    input  logic [63:0] i_key_word1,
    input  logic [63:0] i_key_word2,
    input  logic [63:0] i_key_word3,
    input  logic [63:0] i_payload_in,
    input  logic [15:0] i_lifetime,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [63:0] o_payload_out,
    output logic [4:0]  o_cleared_count,
    output logic [4:0]  o_entry_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    logic        r_out_valid;
    logic [15:0] r_default_lifetime;
    logic [2:0]  r_cmd;
    logic        busy;
    t_ctl        ctl;
    t_sts        sts;

    assign o_ready     = !busy;
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;

    // config register and command hold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_default_lifetime <= 16'd300;
            r_out_valid        <= 1'b0;
        end else begin
            if (i_cfg_valid) r_default_lifetime <= i_cfg_data;
            if (ctl.finish)           r_out_valid <= 1'b1;
            else if (i_ready)         r_out_valid <= 1'b0;
        end
        if (ctl.load) r_cmd <= i_command;
    end

    tke_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_valid),
        .i_cmd      (t_cmd'(r_cmd)),
        .i_sts      (sts),
        .i_out_free (!r_out_valid || i_ready),
        .o_busy     (busy),
        .o_ctl      (ctl)
    );

    tke_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_ctl              (ctl),
        .i_command          (i_command),
        .i_key              ({i_key_word0, i_key_word1, i_key_word2, i_key_word3}),
        .i_payload          (i_payload_in),
        .i_lifetime         (i_lifetime),
        .i_default_lifetime (r_default_lifetime),
        .o_sts              (sts),
        .o_status           (o_status),
        .o_payload          (o_payload_out),
        .o_cleared          (o_cleared_count),
        .o_count            (o_entry_count)
    );

endmodule
